// File: rtl/fbfl_pkg.sv
`default_nettype none

package fbfl_pkg;

	// Pool size default
	localparam int NUM_BLOCKS_DEF = 64;

	// Fixed field widths
	localparam int REQ_W    = 16;
	localparam int IDX_W    = 6;
	localparam int STATUS_W = 2;

	localparam logic [REQ_W-1:0] MAX_SIZE_RST = 16'd128;

	// Request opcodes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Result status codes
	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd2;

	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_POP
	} state_t;

endpackage

`default_nettype wire

// File: rtl/fbfl_link_ram.sv
`default_nettype none

// Next-link store: one write port, one read port, registered read data.
module fbfl_link_ram #(
	parameter int NUM_BLOCKS = fbfl_pkg::NUM_BLOCKS_DEF,
	parameter int ADDR_W     = $clog2(NUM_BLOCKS),
	parameter int LINK_W     = $clog2(NUM_BLOCKS + 1)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [LINK_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [LINK_W-1:0] rdata
);

	logic [LINK_W-1:0] mem_q [NUM_BLOCKS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/fbfl_ctrl.sv
`default_nettype none

// Free-list sequencer: init sweep, push on free, pop through the link store.
module fbfl_ctrl #(
	parameter int NUM_BLOCKS = fbfl_pkg::NUM_BLOCKS_DEF,
	parameter int ADDR_W     = $clog2(NUM_BLOCKS),
	parameter int LINK_W     = $clog2(NUM_BLOCKS + 1)
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic                            op,
	input  wire logic [fbfl_pkg::REQ_W-1:0]      request_size,
	input  wire logic [fbfl_pkg::IDX_W-1:0]      block_index,
	input  wire logic [fbfl_pkg::REQ_W-1:0]      max_size,
	output logic                                 busy,
	output logic                                 done,
	output logic      [fbfl_pkg::STATUS_W-1:0]   status,
	output logic      [fbfl_pkg::IDX_W-1:0]      granted_index,
	output logic      [fbfl_pkg::REQ_W-1:0]      granted_size,
	output logic                                 mem_we,
	output logic      [ADDR_W-1:0]               mem_waddr,
	output logic      [LINK_W-1:0]               mem_wdata,
	output logic                                 mem_re,
	output logic      [ADDR_W-1:0]               mem_raddr,
	input  wire logic [LINK_W-1:0]               mem_rdata
);

	fbfl_pkg::state_t state_q, state_d;

	logic [LINK_W-1:0]               head_q, head_d;
	logic [ADDR_W-1:0]               init_cnt_q, init_cnt_d;
	logic                            done_q, done_d;
	logic [fbfl_pkg::STATUS_W-1:0]   status_q, status_d;
	logic [fbfl_pkg::IDX_W-1:0]      gidx_q, gidx_d;
	logic [fbfl_pkg::REQ_W-1:0]      gsize_q, gsize_d;

	logic accept;
	logic list_empty;
	logic blk_in_pool;

	assign busy        = (state_q != fbfl_pkg::ST_IDLE);
	assign accept      = start && !busy;
	assign list_empty  = (32'(head_q) >= NUM_BLOCKS);
	assign blk_in_pool = (32'(block_index) < NUM_BLOCKS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= fbfl_pkg::ST_INIT;
			head_q     <= '0;
			init_cnt_q <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			head_q     <= head_d;
			init_cnt_q <= init_cnt_d;
			done_q     <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		status_q <= status_d;
		gidx_q   <= gidx_d;
		gsize_q  <= gsize_d;
	end

	always_comb begin
		state_d    = state_q;
		head_d     = head_q;
		init_cnt_d = init_cnt_q;
		done_d     = 1'b0;
		status_d   = status_q;
		gidx_d     = gidx_q;
		gsize_d    = gsize_q;
		mem_we     = 1'b0;
		mem_waddr  = init_cnt_q;
		mem_wdata  = LINK_W'(init_cnt_q) + LINK_W'(1);
		mem_re     = 1'b0;
		mem_raddr  = head_q[ADDR_W-1:0];

		case (state_q)
			fbfl_pkg::ST_INIT: begin
				// chain entry i to i+1; the last one gets the null link
				mem_we     = 1'b1;
				init_cnt_d = init_cnt_q + ADDR_W'(1);
				if (init_cnt_q == ADDR_W'(NUM_BLOCKS - 1)) begin
					state_d = fbfl_pkg::ST_IDLE;
				end
			end
			fbfl_pkg::ST_IDLE: begin
				if (accept) begin
					gidx_d  = '0;
					gsize_d = '0;
					if (op == fbfl_pkg::OP_FREE) begin
						done_d   = 1'b1;
						status_d = fbfl_pkg::STATUS_OK;
						if (blk_in_pool) begin
							mem_we    = 1'b1;
							mem_waddr = ADDR_W'(block_index);
							mem_wdata = head_q;
							head_d    = LINK_W'(block_index);
						end
					end else if (request_size > max_size) begin
						done_d   = 1'b1;
						status_d = fbfl_pkg::STATUS_TOO_LARGE;
					end else if (list_empty) begin
						done_d   = 1'b1;
						status_d = fbfl_pkg::STATUS_EMPTY;
					end else begin
						mem_re  = 1'b1;
						state_d = fbfl_pkg::ST_POP;
					end
				end
			end
			fbfl_pkg::ST_POP: begin
				head_d   = mem_rdata;
				done_d   = 1'b1;
				status_d = fbfl_pkg::STATUS_OK;
				gidx_d   = fbfl_pkg::IDX_W'(head_q);
				gsize_d  = max_size;
				state_d  = fbfl_pkg::ST_IDLE;
			end
			default: begin
				state_d = fbfl_pkg::ST_IDLE;
			end
		endcase
	end

	assign done          = done_q;
	assign status        = status_q;
	assign granted_index = gidx_q;
	assign granted_size  = gsize_q;

`ifndef SYNTHESIS
	a_pop_finishes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fbfl_pkg::ST_POP) |=> (state_q == fbfl_pkg::ST_IDLE) && done_q)
		else $error("pop did not complete in one cycle");

	a_head_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(head_q) <= NUM_BLOCKS))
		else $error("list head beyond null link");

	a_free_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (op == fbfl_pkg::OP_FREE)) |=>
		done_q && (status_q == fbfl_pkg::STATUS_OK) && (gidx_q == '0) && (gsize_q == '0))
		else $error("free request gave wrong result");

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(accept) || $past(state_q == fbfl_pkg::ST_POP))
		else $error("result strobe without request");
`endif

endmodule

`default_nettype wire

// File: rtl/fixed_block_free_list_allocator_unit.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+-----------------------------------------
// request  | start / busy         | op, request_size, block_index
// result   | done (one-cycle)     | status, granted_index, granted_size
// config   | cfg_we               | cfg_wdata (block size)
//
// Free, refused allocate: result in the cycle after the request; busy stays low.
// Granted allocate: result registered from ST_POP; busy is high for one cycle
//   while the registered link memory read returns the new head.
// Reset: head goes to block 0, then an init sweep of all NUM_BLOCKS entries
//   (64 by default) chains the link memory; busy is high for the whole sweep.
// The result side cannot stall: done marks each result for exactly one cycle.
`default_nettype none

module fixed_block_free_list_allocator_unit #(
	parameter int NUM_BLOCKS = fbfl_pkg::NUM_BLOCKS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// request
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          op,
	input  wire logic [fbfl_pkg::REQ_W-1:0]    request_size,
	input  wire logic [fbfl_pkg::IDX_W-1:0]    block_index,
	// result
	output logic                               done,
	output logic      [fbfl_pkg::STATUS_W-1:0] status,
	output logic      [fbfl_pkg::IDX_W-1:0]    granted_index,
	output logic      [fbfl_pkg::REQ_W-1:0]    granted_size,
	// block size register
	input  wire logic                          cfg_we,
	input  wire logic [fbfl_pkg::REQ_W-1:0]    cfg_wdata
);

	localparam int ADDR_W = $clog2(NUM_BLOCKS);
	// one extra code for the null link
	localparam int LINK_W = $clog2(NUM_BLOCKS + 1);

	// block size; requests above it are refused
	logic [fbfl_pkg::REQ_W-1:0] max_size_q;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [LINK_W-1:0] mem_wdata;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;
	logic [LINK_W-1:0] mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_size_q <= fbfl_pkg::MAX_SIZE_RST;
		end else if (cfg_we) begin
			max_size_q <= cfg_wdata;
		end
	end

	// sequencer: owns the head register and the result registers
	fbfl_ctrl #(
		.NUM_BLOCKS (NUM_BLOCKS),
		.ADDR_W     (ADDR_W),
		.LINK_W     (LINK_W)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.op            (op),
		.request_size  (request_size),
		.block_index   (block_index),
		.max_size      (max_size_q),
		.busy          (busy),
		.done          (done),
		.status        (status),
		.granted_index (granted_index),
		.granted_size  (granted_size),
		.mem_we        (mem_we),
		.mem_waddr     (mem_waddr),
		.mem_wdata     (mem_wdata),
		.mem_re        (mem_re),
		.mem_raddr     (mem_raddr),
		.mem_rdata     (mem_rdata)
	);

	// per-block next link; null link is NUM_BLOCKS
	fbfl_link_ram #(
		.NUM_BLOCKS (NUM_BLOCKS),
		.ADDR_W     (ADDR_W),
		.LINK_W     (LINK_W)
	) u_link_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

`default_nettype wire
